// ===== hw/rtl/tcce_pkg.sv =====
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int ColumnsDef = 80;
  localparam int RowsDef    = 25;
  localparam int FifoDepth  = 2;

  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int LIN_OUT_W  = 11;
  localparam int CELL_W     = 16;

  localparam logic [CELL_W-1:0] CELL_RESET = 16'h0F00;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    K_PRINT,
    K_LF,
    K_CR,
    K_TAB,
    K_BS,
    K_NOP,
    K_CLEAR,
    K_READ
  } kind_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ
  } state_e;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } sweep_e;

  typedef struct packed {
    kind_e              kind;
    logic [CELL_W-1:0]  word;
    logic               rd_ok;
    logic [4:0]         rd_row;
    logic [6:0]         rd_col;
  } cmd_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic [LIN_OUT_W-1:0] lin;
    logic [CELL_W-1:0]    cell_val;
    logic                 scrolled;
  } res_t;

endpackage

// ===== hw/rtl/tcce_front.sv =====
`timescale 1ns / 1ps

module tcce_front import tcce_pkg::*; #(
  parameter int COLUMNS = ColumnsDef,
  parameter int ROWS    = RowsDef
) (
  input  logic [1:0] operation_i,
  input  logic [7:0] char_code_i,
  input  logic [3:0] fore_colour_i,
  input  logic [3:0] back_colour_i,
  input  logic [4:0] read_row_i,
  input  logic [6:0] read_col_i,
  output cmd_t       cmd_o
);

  always_comb begin
    cmd_o.kind   = K_NOP;
    cmd_o.word   = {back_colour_i, fore_colour_i, CH_NUL};
    cmd_o.rd_ok  = (int'(read_row_i) < ROWS) && (int'(read_col_i) < COLUMNS);
    cmd_o.rd_row = read_row_i;
    cmd_o.rd_col = read_col_i;
    unique case (operation_i)
      OP_PUT: begin
        unique case (char_code_i) inside
          CH_LF:  cmd_o.kind = K_LF;
          CH_CR:  cmd_o.kind = K_CR;
          CH_TAB: cmd_o.kind = K_TAB;
          CH_BS: begin
            cmd_o.kind = K_BS;
            cmd_o.word = {back_colour_i, fore_colour_i, CH_SPACE};
          end
          [CH_SPACE:CH_TILDE]: begin
            cmd_o.kind = K_PRINT;
            cmd_o.word = {back_colour_i, fore_colour_i, char_code_i};
          end
          default: cmd_o.kind = K_NOP;
        endcase
      end
      OP_CLEAR: cmd_o.kind = K_CLEAR;
      OP_READ:  cmd_o.kind = K_READ;
      default:  cmd_o.kind = K_NOP;
    endcase
  end

endmodule

// ===== hw/rtl/tcce_cmd_fifo.sv =====
`timescale 1ns / 1ps

module tcce_cmd_fifo import tcce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_data_i,
  input  logic rd_en_i,
  output cmd_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CNT_W = $clog2(FifoDepth + 1);

  cmd_t             ent_q [FifoDepth];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o    = (count_q == CNT_W'(FifoDepth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FifoDepth - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FifoDepth - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ent_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FifoDepth))
    else $error("command queue count out of range");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && rd_en_i) |=> count_q == $past(count_q))
    else $error("simultaneous write and read changed the count");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> (count_q != '0))
    else $error("command queue read while empty");

endmodule

// ===== hw/rtl/tcce_back.sv =====
`timescale 1ns / 1ps

module tcce_back import tcce_pkg::*; #(
  parameter int COLUMNS = ColumnsDef,
  parameter int ROWS    = RowsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  output res_t res_o,
  output logic res_valid_o,
  input  logic res_pop_i,
  output logic busy_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int XW    = $clog2(COLUMNS + 8);
  localparam int RXW   = $clog2(ROWS + 1);

  state_e            state_q, state_d;
  sweep_e            sweep_q, sweep_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [CELL_W-1:0] fill_q, fill_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic              scroll_en_q;
  logic              out_valid_q;
  res_t              res_q, res_d;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic              we;

  // put character cursor logic
  logic [XW-1:0]     col_n;
  logic [RXW-1:0]    row_n;
  logic              row_inc;
  logic [CW-1:0]     wcol;
  logic              put_we;
  logic              put_scroll;
  logic [AW-1:0]     put_addr;
  logic [AW-1:0]     rd_addr;
  logic [AW:0]       src;
  logic              copy;

  logic              slot_free;
  logic              res_push;
  logic [CW-1:0]     res_col;
  logic [RW-1:0]     res_row;
  logic [CELL_W-1:0] res_cell;
  logic              res_scr;
  logic [AW-1:0]     lin;

  always_comb begin
    col_n      = XW'(col_q);
    row_inc    = 1'b0;
    wcol       = col_q;
    put_we     = 1'b0;
    put_scroll = 1'b0;
    unique case (cmd_i.kind)
      K_LF: begin
        col_n   = '0;
        row_inc = 1'b1;
      end
      K_CR:  col_n = '0;
      K_TAB: col_n = (XW'(col_q) + XW'(8)) & ~XW'(7);
      K_BS: begin
        if (col_q != '0) begin
          col_n  = XW'(col_q) - XW'(1);
          wcol   = col_q - CW'(1);
          put_we = 1'b1;
        end
      end
      K_PRINT: begin
        put_we = 1'b1;
        col_n  = XW'(col_q) + XW'(1);
      end
      default: ;
    endcase
    if (col_n >= XW'(COLUMNS)) begin
      col_n   = '0;
      row_inc = 1'b1;
    end
    row_n = RXW'(row_q) + RXW'(row_inc);
    if (row_n >= RXW'(ROWS)) begin
      if (scroll_en_q) begin
        row_n      = RXW'(ROWS - 1);
        put_scroll = 1'b1;
      end else begin
        row_n = '0;
      end
    end
    put_addr = AW'(row_q) * AW'(COLUMNS) + AW'(wcol);
    rd_addr  = AW'(cmd_i.rd_row) * AW'(COLUMNS) + AW'(cmd_i.rd_col);
  end

  assign slot_free = !out_valid_q || res_pop_i;
  assign src       = (AW + 1)'(ptr_q) + (AW + 1)'(COLUMNS + 1);
  assign copy      = (sweep_q == SW_SCROLL) && (ptr_q < AW'(CELLS - COLUMNS));

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    ptr_d     = ptr_q;
    fill_d    = fill_q;
    col_d     = col_q;
    row_d     = row_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    waddr     = ptr_q;
    wdata     = fill_q;
    raddr     = AW'(COLUMNS);
    res_push  = 1'b0;
    res_col   = col_q;
    res_row   = row_q;
    res_cell  = '0;
    res_scr   = 1'b0;
    unique case (state_q)
      ST_SWEEP: begin
        we    = 1'b1;
        wdata = copy ? rdata_q : fill_q;
        if (src < (AW + 1)'(CELLS)) begin
          raddr = src[AW-1:0];
        end
        if (ptr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
          ptr_d   = '0;
          if (sweep_q != SW_INIT) begin
            res_push = 1'b1;
            res_scr  = (sweep_q == SW_SCROLL);
          end
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            K_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              fill_d  = {cmd_i.word[CELL_W-1:8], CH_NUL};
              sweep_d = SW_CLEAR;
              ptr_d   = '0;
              state_d = ST_SWEEP;
            end
            K_READ: begin
              if (cmd_i.rd_ok) begin
                raddr   = rd_addr;
                state_d = ST_READ;
              end else begin
                res_push = 1'b1;
              end
            end
            default: begin
              we    = put_we;
              waddr = put_addr;
              wdata = cmd_i.word;
              col_d = CW'(col_n);
              row_d = RW'(row_n);
              if (put_scroll) begin
                fill_d  = {cmd_i.word[CELL_W-1:8], CH_NUL};
                sweep_d = SW_SCROLL;
                ptr_d   = '0;
                state_d = ST_SWEEP;
              end else begin
                res_push = 1'b1;
                res_col  = CW'(col_n);
                res_row  = RW'(row_n);
              end
            end
          endcase
        end
      end
      ST_READ: begin
        res_push = 1'b1;
        res_cell = rdata_q;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    lin          = AW'(res_row) * AW'(COLUMNS) + AW'(res_col);
    res_d.col      = COL_OUT_W'(res_col);
    res_d.row      = ROW_OUT_W'(res_row);
    res_d.lin      = LIN_OUT_W'(lin);
    res_d.cell_val = res_cell;
    res_d.scrolled = res_scr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= SW_INIT;
      ptr_q       <= '0;
      fill_q      <= CELL_RESET;
      col_q       <= '0;
      row_q       <= '0;
      scroll_en_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      ptr_q   <= ptr_d;
      fill_q  <= fill_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (cfg_we_i) begin
        scroll_en_q <= cfg_wdata_i;
      end
      if (res_push) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign res_o       = res_q;
  assign res_valid_o = out_valid_q;
  assign busy_o      = (state_q == ST_SWEEP) && (sweep_q == SW_INIT);

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(col_q) < COLUMNS) && (int'(row_q) < ROWS))
    else $error("cursor outside the screen");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (!out_valid_q || res_pop_i))
    else $error("result written over an unread result");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && sweep_q == SW_SCROLL) |-> (row_q == RW'(ROWS - 1)))
    else $error("scroll running with cursor off the last row");

  a_clear_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && sweep_q == SW_CLEAR) |-> (col_q == '0 && row_q == '0))
    else $error("clear running with cursor not at home");

endmodule

// ===== hw/rtl/text_console_char_engine.sv =====
`timescale 1ns / 1ps

// channel  | handshake          | beat
// input    | push / full        | operation, char, colours, read row and column
// result   | empty / pop        | cursor column, row, linear, cell value, scrolled
// config   | cfg_we_i           | cfg_wdata_i, scroll enable
//
// after reset the screen memory is swept to blank, with full held high until it ends
// put, bad read and unused op end in the idle state; a cell read adds the read state
// clear and scroll walk the whole screen memory
// a two-beat command queue lets input beats land while the back end is busy
// a finished result holds in the output register until popped; the back end takes
// no command while it sweeps or reads, or while that register is occupied and unpopped

module text_console_char_engine import tcce_pkg::*; #(
  parameter int COLUMNS = ColumnsDef,
  parameter int ROWS    = RowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  fore_colour_i,
  input  logic [3:0]  back_colour_i,
  input  logic [4:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [10:0] cursor_linear_o,
  output logic [15:0] cell_value_o,
  output logic        scrolled_o
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic busy;
  logic res_valid;
  res_t res;

  tcce_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .operation_i   (operation_i),
    .char_code_i   (char_code_i),
    .fore_colour_i (fore_colour_i),
    .back_colour_i (back_colour_i),
    .read_row_i    (read_row_i),
    .read_col_i    (read_col_i),
    .cmd_o         (front_cmd)
  );

  tcce_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push && !full),
    .wr_data_i (front_cmd),
    .rd_en_i   (q_pop),
    .rd_data_o (q_cmd),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  tcce_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (q_cmd),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop && res_valid),
    .busy_o      (busy)
  );

  assign full            = q_full || busy;
  assign empty           = !res_valid;
  assign cursor_col_o    = res.col;
  assign cursor_row_o    = res.row;
  assign cursor_linear_o = res.lin;
  assign cell_value_o    = res.cell_val;
  assign scrolled_o      = res.scrolled;

endmodule

// ===== dv/text_console_char_engine_test.sv =====
`timescale 1ns / 1ps

module text_console_char_engine_test;
  import tcce_pkg::*;

  localparam int COLS = ColumnsDef;
  localparam int ROWS = RowsDef;
  localparam int CELLS = COLS * ROWS;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_TOP = 8'hFF;
  localparam int MAX_WAIT = 11;
  localparam int HOLD_OFF = 400;
  localparam int SETTLE_CYCLES = 20;

  class screen_scoreboard;
    logic [CELL_W-1:0] cells [CELLS];
    int unsigned col;
    int unsigned row;
    bit scroll_en;
    res_t expected_q[$];
    int errors;
    int items;
    int scrolls;
    int reads;
    int clears;

    function new();
      foreach (cells[i]) cells[i] = CELL_RESET;
      col = 0;
      row = 0;
      scroll_en = 1'b1;
      errors = 0;
      items = 0;
      scrolls = 0;
      reads = 0;
      clears = 0;
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] ch, logic [3:0] fg, logic [3:0] bg,
                             logic [4:0] rr, logic [6:0] rc);
      logic [CELL_W-1:0] blank;
      res_t want;
      int i;
      blank = {bg, fg, CH_NUL};
      want = '0;
      items++;
      case (op)
        OP_PUT: begin
          case (ch)
            CH_LF: begin
              col = 0;
              row++;
            end
            CH_CR: col = 0;
            CH_TAB: col = (col + 8) / 8 * 8;
            CH_BS: begin
              if (col > 0) begin
                col--;
                cells[row * COLS + col] = {bg, fg, CH_SPACE};
              end
            end
            default: begin
              if (ch >= CH_SPACE && ch <= CH_TILDE) begin
                cells[row * COLS + col] = {bg, fg, ch};
                col++;
              end
            end
          endcase
          if (col >= COLS) begin
            col = 0;
            row++;
          end
          if (row >= ROWS) begin
            if (scroll_en) begin
              for (i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
              for (i = CELLS - COLS; i < CELLS; i++) cells[i] = blank;
              row = ROWS - 1;
              want.scrolled = 1'b1;
              scrolls++;
            end else begin
              row = 0;
            end
          end
        end
        OP_CLEAR: begin
          foreach (cells[j]) cells[j] = blank;
          col = 0;
          row = 0;
          clears++;
        end
        OP_READ: begin
          reads++;
          if (rr < ROWS && rc < COLS) want.cell_val = cells[rr * COLS + rc];
        end
        default: ;
      endcase
      want.col = COL_OUT_W'(col);
      want.row = ROW_OUT_W'(row);
      want.lin = LIN_OUT_W'(row * COLS + col);
      expected_q.push_back(want);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: cursor_col %0d cursor_row %0d", got.col, got.row);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.col !== want.col) begin
        $error("cursor_col: expected %0d, actual %0d", want.col, got.col);
        errors++;
      end
      if (got.row !== want.row) begin
        $error("cursor_row: expected %0d, actual %0d", want.row, got.row);
        errors++;
      end
      if (got.lin !== want.lin) begin
        $error("cursor_linear: expected %0d, actual %0d", want.lin, got.lin);
        errors++;
      end
      if (got.cell_val !== want.cell_val) begin
        $error("cell_value: expected %h, actual %h", want.cell_val, got.cell_val);
        errors++;
      end
      if (got.scrolled !== want.scrolled) begin
        $error("scrolled: expected %0d, actual %0d", want.scrolled, got.scrolled);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        push;
  logic        full;
  logic [1:0]  operation_i;
  logic [7:0]  char_code_i;
  logic [3:0]  fore_colour_i;
  logic [3:0]  back_colour_i;
  logic [4:0]  read_row_i;
  logic [6:0]  read_col_i;
  logic        empty;
  logic        pop;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic [10:0] cursor_linear_o;
  logic [15:0] cell_value_o;
  logic        scrolled_o;

  screen_scoreboard sb;
  int hold_cycles = 0;
  int sent_count = 0;
  int popped_count = 0;

  always #4 clk_i = ~clk_i;

  text_console_char_engine DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .char_code_i    (char_code_i),
    .fore_colour_i  (fore_colour_i),
    .back_colour_i  (back_colour_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .empty          (empty),
    .pop            (pop),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_linear_o(cursor_linear_o),
    .cell_value_o   (cell_value_o),
    .scrolled_o     (scrolled_o)
  );

  function automatic int draw_wait(int count, int stretch, int quiet_slot);
    if ((count / stretch) % 4 == quiet_slot) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic [3:0] fg,
                           input logic [3:0] bg, input logic [4:0] rr, input logic [6:0] rc);
    int gap;
    gap = draw_wait(sent_count, 40, 3);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push = 1'b1;
    operation_i = op;
    char_code_i = ch;
    fore_colour_i = fg;
    back_colour_i = bg;
    read_row_i = rr;
    read_col_i = rc;
    do @(posedge clk_i); while (full);
    sb.note_input(op, ch, fg, bg, rr, rc);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_random_items(input int count);
    int w;
    logic [1:0] op;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    for (int n = 0; n < count; n++) begin
      w = $urandom_range(0, 99);
      op = OP_PUT;
      ch = 8'($urandom_range(0, 255));
      rr = 5'($urandom_range(0, 31));
      rc = 7'($urandom_range(0, 127));
      if (w < 45) ch = 8'($urandom_range(CH_SPACE, CH_TILDE));
      else if (w < 65) ch = CH_LF;
      else if (w < 69) ch = CH_CR;
      else if (w < 73) ch = CH_TAB;
      else if (w < 78) ch = CH_BS;
      else if (w < 83) begin
        if ($urandom_range(0, 1) == 1) ch = ch | 8'h80;
        else ch = 8'($urandom_range(0, 31));
      end else if (w < 84) op = OP_CLEAR;
      else if (w < 99) begin
        op = OP_READ;
        if ($urandom_range(0, 9) != 0) begin
          rr = 5'($urandom_range(0, ROWS - 1));
          rc = 7'($urandom_range(0, COLS - 1));
        end
      end else op = OP_SPARE;
      send_item(op, ch, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), rr, rc);
    end
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_scroll(input bit enable);
    cfg_we_i = 1'b1;
    cfg_wdata_i = enable;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.scroll_en = enable;
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    push = 1'b0;
    operation_i = OP_PUT;
    char_code_i = CH_NUL;
    fore_colour_i = 4'h0;
    back_colour_i = 4'h0;
    read_row_i = 5'd0;
    read_col_i = 7'd0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(OP_READ, CH_NUL, 4'h0, 4'h0, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 4'h0, 4'h0, 5'd24, 7'd79);
    send_item(OP_PUT, CH_SPACE, 4'hF, 4'h0, 5'd0, 7'd0);
    send_item(OP_PUT, CH_TILDE, 4'h0, 4'hF, 5'd0, 7'd0);
    send_item(OP_PUT, CH_DEL, 4'h1, 4'h2, 5'd0, 7'd0);
    send_item(OP_PUT, CH_TOP, 4'h1, 4'h2, 5'd0, 7'd0);
    send_item(OP_PUT, CH_NUL, 4'h1, 4'h2, 5'd0, 7'd0);
    send_item(OP_PUT, CH_TAB, 4'h1, 4'h2, 5'd0, 7'd0);
    send_item(OP_PUT, CH_BS, 4'h3, 4'hC, 5'd0, 7'd0);
    send_item(OP_PUT, CH_CR, 4'h1, 4'h2, 5'd0, 7'd0);
    send_item(OP_PUT, CH_BS, 4'h3, 4'hC, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 4'h0, 4'h0, 5'd0, 7'd7);
    send_item(OP_PUT, CH_LF, 4'h1, 4'h2, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 4'h0, 4'h0, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 4'h0, 4'h0, 5'd0, 7'd1);
    send_item(OP_READ, CH_NUL, 4'h0, 4'h0, 5'd25, 7'd0);
    send_item(OP_READ, CH_NUL, 4'h0, 4'h0, 5'd0, 7'd80);
    send_item(OP_READ, CH_TOP, 4'hF, 4'hF, 5'd31, 7'd127);
    send_item(OP_SPARE, CH_SPACE, 4'h4, 4'h4, 5'd3, 7'd3);
    send_item(OP_CLEAR, CH_NUL, 4'h5, 4'hA, 5'd0, 7'd0);
    send_item(OP_READ, CH_NUL, 4'h0, 4'h0, 5'd12, 7'd40);

    send_random_items(100);
    // receiver stalls so the command queue backs up
    hold_cycles = HOLD_OFF;
    send_random_items(100);
    wait_drained();
    write_scroll(1'b0);
    send_random_items(150);
    wait_drained();
    write_scroll(1'b1);
    send_random_items(150);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("covered %0d items: %0d scrolls, %0d cell reads, %0d clears", sb.items,
             sb.scrolls, sb.reads, sb.clears);
    $display("scrolling exercised both enabled and disabled, with a long result stall");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    res_t got;
    int stall;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        pop = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      stall = draw_wait(popped_count, 28, 1);
      if (stall > 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop = 1'b1;
      do @(posedge clk_i); while (empty);
      got.col = cursor_col_o;
      got.row = cursor_row_o;
      got.lin = cursor_linear_o;
      got.cell_val = cell_value_o;
      got.scrolled = scrolled_o;
      sb.check_result(got);
      popped_count++;
      @(negedge clk_i);
    end
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
